// ===== src/icf_pkg.sv =====
package icf_pkg;

  localparam int NumRegs = 256;
  localparam int RegW = $clog2(NumRegs);
  localparam int DataW = 32;

  localparam logic [4:0] OP_LDC  = 5'd0;
  localparam logic [4:0] OP_ADD  = 5'd1;
  localparam logic [4:0] OP_SUB  = 5'd2;
  localparam logic [4:0] OP_MUL  = 5'd3;
  localparam logic [4:0] OP_DIV  = 5'd4;
  localparam logic [4:0] OP_MOD  = 5'd5;
  localparam logic [4:0] OP_NEG  = 5'd6;
  localparam logic [4:0] OP_CEQ  = 5'd7;
  localparam logic [4:0] OP_CNE  = 5'd8;
  localparam logic [4:0] OP_CLT  = 5'd9;
  localparam logic [4:0] OP_CLE  = 5'd10;
  localparam logic [4:0] OP_CGT  = 5'd11;
  localparam logic [4:0] OP_CGE  = 5'd12;
  localparam logic [4:0] OP_LAND = 5'd13;
  localparam logic [4:0] OP_LOR  = 5'd14;
  localparam logic [4:0] OP_LNOT = 5'd15;
  localparam logic [4:0] OP_BAND = 5'd16;
  localparam logic [4:0] OP_BOR  = 5'd17;
  localparam logic [4:0] OP_BXOR = 5'd18;
  localparam logic [4:0] OP_BNOT = 5'd19;
  localparam logic [4:0] OP_SHL  = 5'd20;
  localparam logic [4:0] OP_SHR  = 5'd21;
  localparam logic [4:0] OP_MOVE = 5'd22;

  localparam logic [1:0] NOTE_PASS = 2'd0;
  localparam logic [1:0] NOTE_FOLD = 2'd1;
  localparam logic [1:0] NOTE_MOVE = 2'd2;

  typedef struct packed {
    logic [4:0]        req_type;
    logic [1:0]        arg_count;
    logic signed [31:0] arg_dest;
    logic signed [31:0] arg_second;
    logic signed [31:0] arg_third;
    logic              start_of_function;
  } in_word_t;

  typedef struct packed {
    logic [4:0]        out_opcode;
    logic [1:0]        out_arg_count;
    logic signed [31:0] out_first;
    logic signed [31:0] out_second;
    logic signed [31:0] out_third;
    logic [1:0]        fold_note;
    logic              changed_so_far;
  } out_word_t;

  typedef struct packed {
    logic             start;
    logic             is_div;
    logic [DataW-1:0] a;
    logic [DataW-1:0] b;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DataW-1:0] result;
  } div_rsp_t;

  function automatic logic in_table(input logic [31:0] r);
    return r < 32'(NumRegs);
  endfunction

endpackage

// ===== src/icf_divider.sv =====
module icf_divider (
  input  logic              clk,
  input  logic              rst,
  input  icf_pkg::div_req_t req,
  output icf_pkg::div_rsp_t rsp
);
  import icf_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_RUN, S_FIX} state_t;

  state_t           state;
  logic [5:0]       count;
  logic [DataW-1:0] quo;
  logic [DataW-1:0] rem;
  logic [DataW-1:0] dvs;
  logic             neg_q;
  logic             neg_r;
  logic             want_div;
  logic [DataW-1:0] result;
  logic             done;
  logic [DataW:0]   rem_shift;
  logic [DataW:0]   rem_sub;

  assign rem_shift = {rem, quo[DataW-1]};
  assign rem_sub = rem_shift - {1'b0, dvs};
  assign rsp.done = done;
  assign rsp.result = result;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (req.start) begin
            neg_q <= req.a[DataW-1] ^ req.b[DataW-1];
            neg_r <= req.a[DataW-1];
            want_div <= req.is_div;
            quo <= req.a[DataW-1] ? -req.a : req.a;
            dvs <= req.b[DataW-1] ? -req.b : req.b;
            rem <= '0;
            count <= '0;
            state <= S_RUN;
          end
        end
        S_RUN: begin
          if (!rem_sub[DataW]) begin
            rem <= rem_sub[DataW-1:0];
            quo <= {quo[DataW-2:0], 1'b1};
          end else begin
            rem <= rem_shift[DataW-1:0];
            quo <= {quo[DataW-2:0], 1'b0};
          end
          count <= count + 6'd1;
          if (count == 6'(DataW - 1)) begin
            state <= S_FIX;
          end
        end
        S_FIX: begin
          if (want_div) begin
            result <= neg_q ? -quo : quo;
          end else begin
            result <= neg_r ? -rem : rem;
          end
          done <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== src/icf_alu.sv =====
module icf_alu (
  input  logic [4:0]           op,
  input  logic [icf_pkg::DataW-1:0] a,
  input  logic [icf_pkg::DataW-1:0] b,
  output logic [icf_pkg::DataW-1:0] y,
  output logic                 ok
);
  import icf_pkg::*;

  logic lt;
  logic gt;
  logic eq;

  assign lt = $signed(a) < $signed(b);
  assign gt = $signed(b) < $signed(a);
  assign eq = a == b;

  always_comb begin
    y = '0;
    ok = 1'b1;
    case (op)
      OP_ADD:  y = a + b;
      OP_SUB:  y = a - b;
      OP_MUL:  y = a * b;
      OP_CEQ:  y = DataW'(eq);
      OP_CNE:  y = DataW'(!eq);
      OP_CLT:  y = DataW'(lt);
      OP_CLE:  y = DataW'(!gt);
      OP_CGT:  y = DataW'(gt);
      OP_CGE:  y = DataW'(!lt);
      OP_LAND: y = DataW'((a != '0) && (b != '0));
      OP_LOR:  y = DataW'((a != '0) || (b != '0));
      OP_BAND: y = a & b;
      OP_BOR:  y = a | b;
      OP_BXOR: y = a ^ b;
      OP_SHL: begin
        ok = b < 32'd32;
        y = a << b[4:0];
      end
      OP_SHR: begin
        ok = b < 32'd32;
        y = DataW'($signed(a) >>> b[4:0]);
      end
      OP_NEG:  y = -a;
      OP_LNOT: y = DataW'(a == '0);
      OP_BNOT: y = ~a;
      OP_MOVE: y = a;
      default: ok = 1'b0;
    endcase
  end

endmodule

// ===== src/ir_constant_folder_core.sv =====
// channel | valid     | ready     | payload
// input   | in_valid  | in_ready  | in_data  (icf_pkg::in_word_t)
// output  | out_valid | out_ready | out_data (icf_pkg::out_word_t)
// An item passes through table read, compute, write back and output in turn,
// with a stop in the radix-2 divider for a div or mod that folds.
// Reset clears the known-register flags and the changed flag.
// A result is held in the output register until taken and blocks the input;
// the next word is accepted in the same cycle the result leaves.
module ir_constant_folder_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  icf_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output icf_pkg::out_word_t out_data
);
  import icf_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_READ, S_EXEC, S_DIV, S_DONE, S_OUT} state_t;

  state_t           state;
  in_word_t         cur;
  logic [NumRegs-1:0] known;
  logic [DataW-1:0] values [NumRegs];
  logic [DataW-1:0] val_a;
  logic [DataW-1:0] val_b;
  logic             kn_a;
  logic             kn_b;
  logic             any_change;
  logic             div_start;
  div_req_t         dreq;
  div_rsp_t         drsp;
  logic [DataW-1:0] alu_y;
  logic             alu_ok;
  logic             is_bin;
  logic             is_un;
  logic             is_ldc;
  logic [RegW-1:0]  d_idx;
  logic [RegW-1:0]  s_idx;
  logic [RegW-1:0]  t_idx;
  logic             d_in;
  logic [DataW-1:0] fold_val;
  logic [1:0]       note;

  assign d_idx = cur.arg_dest[RegW-1:0];
  assign s_idx = cur.arg_second[RegW-1:0];
  assign t_idx = cur.arg_third[RegW-1:0];
  assign d_in = in_table(cur.arg_dest);

  assign is_ldc = (cur.req_type == OP_LDC) && (cur.arg_count >= 2'd2);
  assign is_bin = (cur.req_type inside {OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_CEQ,
                                        OP_CNE, OP_CLT, OP_CLE, OP_CGT, OP_CGE, OP_LAND,
                                        OP_LOR, OP_BAND, OP_BOR, OP_BXOR, OP_SHL, OP_SHR})
                  && (cur.arg_count == 2'd3);
  assign is_un = (cur.req_type inside {OP_NEG, OP_LNOT, OP_BNOT, OP_MOVE})
                 && (cur.arg_count >= 2'd2);

  icf_alu u_alu (
    .op(cur.req_type),
    .a (val_a),
    .b (val_b),
    .y (alu_y),
    .ok(alu_ok)
  );

  icf_divider u_div (
    .clk(clk),
    .rst(rst),
    .req(dreq),
    .rsp(drsp)
  );

  assign dreq = '{start: div_start, is_div: (cur.req_type == OP_DIV), a: val_a, b: val_b};
  assign in_ready = (state == S_IDLE) || (state == S_OUT && out_ready);

  always_ff @(posedge clk) begin
    if (state == S_READ) begin
      val_a <= values[s_idx];
      val_b <= values[t_idx];
    end
    if (state == S_DONE && d_in) begin
      if (note != NOTE_PASS) begin
        values[d_idx] <= fold_val;
      end else if (is_ldc) begin
        values[d_idx] <= cur.arg_second;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      known <= '0;
      any_change <= 1'b0;
      out_valid <= 1'b0;
      div_start <= 1'b0;
    end else begin
      div_start <= 1'b0;
      case (state)
        S_IDLE, S_OUT: begin
          if (state == S_IDLE || out_ready) begin
            out_valid <= 1'b0;
            state <= S_IDLE;
            if (in_valid) begin
              cur <= in_data;
              if (in_data.start_of_function) begin
                known <= '0;
                any_change <= 1'b0;
              end
              state <= S_READ;
            end
          end
        end
        S_READ: begin
          kn_a <= in_table(cur.arg_second) && known[s_idx];
          kn_b <= in_table(cur.arg_third) && known[t_idx];
          state <= S_EXEC;
        end
        S_EXEC: begin
          note <= NOTE_PASS;
          fold_val <= alu_y;
          state <= S_DONE;
          if (is_bin && kn_a && kn_b) begin
            if (cur.req_type inside {OP_DIV, OP_MOD}) begin
              if (val_b != '0) begin
                div_start <= 1'b1;
                state <= S_DIV;
              end
            end else if (alu_ok) begin
              note <= NOTE_FOLD;
            end
          end else if (is_un && kn_a) begin
            note <= cur.req_type == OP_MOVE ? NOTE_MOVE : NOTE_FOLD;
          end
        end
        S_DIV: begin
          if (drsp.done) begin
            fold_val <= drsp.result;
            note <= NOTE_FOLD;
            state <= S_DONE;
          end
        end
        S_DONE: begin
          out_valid <= 1'b1;
          state <= S_OUT;
          out_data.fold_note <= note;
          if (note != NOTE_PASS) begin
            if (d_in) known[d_idx] <= 1'b1;
            any_change <= 1'b1;
            out_data.out_opcode <= OP_LDC;
            out_data.out_arg_count <= 2'd2;
            out_data.out_first <= cur.arg_dest;
            out_data.out_second <= fold_val;
            out_data.out_third <= '0;
            out_data.changed_so_far <= 1'b1;
          end else begin
            if (is_ldc) begin
              if (d_in) known[d_idx] <= 1'b1;
            end else if (cur.arg_count >= 2'd1 && d_in) begin
              known[d_idx] <= 1'b0;
            end
            out_data.out_opcode <= cur.req_type;
            out_data.out_arg_count <= cur.arg_count;
            out_data.out_first <= cur.arg_count >= 2'd1 ? cur.arg_dest : '0;
            out_data.out_second <= cur.arg_count >= 2'd2 ? cur.arg_second : '0;
            out_data.out_third <= cur.arg_count >= 2'd3 ? cur.arg_third : '0;
            out_data.changed_so_far <= any_change;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== tb/sv/ir_constant_folder_core_tb.sv =====
`timescale 1ns / 100ps

module ir_constant_folder_core_tb;
  import icf_pkg::*;

  localparam int MaxCycles = 400000;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_word_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_word_t out_data;

  ir_constant_folder_core dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  in_word_t  pending_words[$];
  out_word_t folded_words[$];
  logic         reg_known[NumRegs];
  logic [31:0]  reg_value[NumRegs];
  logic         fn_changed;
  int           errors = 0;
  int           cycles = 0;
  int           hold_cycles = 0;
  bit           calm = 1'b0;
  bit           in_taken = 1'b0;
  bit           stimulus_done = 1'b0;

  function automatic bit is_binop(logic [4:0] op);
    return (op >= OP_ADD && op <= OP_MOD) || (op >= OP_CEQ && op <= OP_LOR) ||
           (op >= OP_BAND && op <= OP_BXOR) || op == OP_SHL || op == OP_SHR;
  endfunction

  function automatic bit is_unop(logic [4:0] op);
    return op == OP_NEG || op == OP_LNOT || op == OP_BNOT || op == OP_MOVE;
  endfunction

  function automatic bit lookup(logic [31:0] r, output logic [31:0] v);
    v = '0;
    if (r >= NumRegs) return 1'b0;
    if (!reg_known[r]) return 1'b0;
    v = reg_value[r];
    return 1'b1;
  endfunction

  function automatic bit fold_pair(logic [4:0] op, logic [31:0] a, logic [31:0] b,
                                   output logic [31:0] res);
    logic signed [31:0] sa, sb;
    sa = a;
    sb = b;
    res = '0;
    case (op)
      OP_ADD: res = a + b;
      OP_SUB: res = a - b;
      OP_MUL: res = a * b;
      OP_DIV, OP_MOD: begin
        if (b == 0) return 1'b0;
        if (a == 32'h8000_0000 && b == 32'hffff_ffff) res = (op == OP_DIV) ? a : 0;
        else res = (op == OP_DIV) ? 32'(sa / sb) : 32'(sa % sb);
      end
      OP_CEQ: res = 32'(a == b);
      OP_CNE: res = 32'(a != b);
      OP_CLT: res = 32'(sa < sb);
      OP_CLE: res = 32'(sa <= sb);
      OP_CGT: res = 32'(sa > sb);
      OP_CGE: res = 32'(sa >= sb);
      OP_LAND: res = 32'(a != 0 && b != 0);
      OP_LOR: res = 32'(a != 0 || b != 0);
      OP_BAND: res = a & b;
      OP_BOR: res = a | b;
      OP_BXOR: res = a ^ b;
      OP_SHL: begin
        if (b >= 32) return 1'b0;
        res = a << b[4:0];
      end
      OP_SHR: begin
        if (b >= 32) return 1'b0;
        res = 32'(sa >>> b[4:0]);
      end
      default: return 1'b0;
    endcase
    return 1'b1;
  endfunction

  function automatic out_word_t fold_word(in_word_t w);
    out_word_t o;
    logic [31:0] a, b, res;
    logic [1:0] note;
    logic [31:0] d;
    note = NOTE_PASS;
    res = '0;
    d = w.arg_dest;
    if (w.start_of_function) begin
      foreach (reg_known[i]) reg_known[i] = 1'b0;
      fn_changed = 1'b0;
    end
    if (w.req_type == OP_LDC && w.arg_count >= 2) begin
      if (d < NumRegs) begin
        reg_known[d] = 1'b1;
        reg_value[d] = w.arg_second;
      end
    end else if (is_binop(w.req_type) && w.arg_count >= 3) begin
      if (lookup(w.arg_second, a) && lookup(w.arg_third, b) &&
          fold_pair(w.req_type, a, b, res)) note = NOTE_FOLD;
    end else if (is_unop(w.req_type) && w.arg_count >= 2) begin
      if (lookup(w.arg_second, a)) begin
        case (w.req_type)
          OP_NEG: begin res = -a; note = NOTE_FOLD; end
          OP_LNOT: begin res = 32'(a == 0); note = NOTE_FOLD; end
          OP_BNOT: begin res = ~a; note = NOTE_FOLD; end
          default: begin res = a; note = NOTE_MOVE; end
        endcase
      end
    end
    if (note != NOTE_PASS) begin
      if (d < NumRegs) begin
        reg_known[d] = 1'b1;
        reg_value[d] = res;
      end
      fn_changed = 1'b1;
      o.out_opcode = OP_LDC;
      o.out_arg_count = 2'd2;
      o.out_first = d;
      o.out_second = res;
      o.out_third = '0;
    end else begin
      if (!(w.req_type == OP_LDC && w.arg_count >= 2) && w.arg_count >= 1 && d < NumRegs)
        reg_known[d] = 1'b0;
      o.out_opcode = w.req_type;
      o.out_arg_count = w.arg_count;
      o.out_first = w.arg_count >= 1 ? w.arg_dest : '0;
      o.out_second = w.arg_count >= 2 ? w.arg_second : '0;
      o.out_third = w.arg_count >= 3 ? w.arg_third : '0;
    end
    o.fold_note = note;
    o.changed_so_far = fn_changed;
    return o;
  endfunction

  function automatic in_word_t make_word(logic [4:0] op, logic [1:0] cnt, logic [31:0] d,
                                         logic [31:0] s, logic [31:0] t, logic sof);
    in_word_t w;
    w.req_type = op;
    w.arg_count = cnt;
    w.arg_dest = d;
    w.arg_second = s;
    w.arg_third = t;
    w.start_of_function = sof;
    return w;
  endfunction

  function automatic logic [31:0] pick_reg();
    case ($urandom_range(0, 19))
      0: return $urandom;
      1: return 32'(NumRegs) + $urandom_range(0, 3);
      2: return 32'hffff_ffff - $urandom_range(0, 2);
      default: return $urandom_range(0, 15);
    endcase
  endfunction

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'hffff_ffff;
      2: return 32'h0;
      3: return 32'h7fff_ffff;
      4: return $urandom_range(0, 40);
      5: return -$urandom_range(1, 40);
      default: return $urandom;
    endcase
  endfunction

  task automatic push_word(in_word_t w);
    pending_words = {pending_words, w};
  endtask

  initial begin
    logic [31:0] extremes[4];
    extremes = '{32'h8000_0000, 32'hffff_ffff, 32'h7fff_ffff, 32'h0};
    foreach (reg_known[i]) reg_known[i] = 1'b0;
    foreach (reg_value[i]) reg_value[i] = '0;
    fn_changed = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    push_word(make_word(OP_LDC, 2, 1, 32'h8000_0000, 0, 1'b1));
    push_word(make_word(OP_LDC, 2, 2, 32'hffff_ffff, 0, 1'b0));
    push_word(make_word(OP_LDC, 2, 3, 0, 0, 1'b0));
    push_word(make_word(OP_LDC, 2, 4, 33, 0, 1'b0));
    push_word(make_word(OP_DIV, 3, 5, 1, 2, 1'b0));
    push_word(make_word(OP_MOD, 3, 6, 1, 2, 1'b0));
    push_word(make_word(OP_DIV, 3, 7, 1, 3, 1'b0));
    push_word(make_word(OP_MOD, 3, 7, 1, 3, 1'b0));
    push_word(make_word(OP_SHL, 3, 8, 2, 4, 1'b0));
    push_word(make_word(OP_SHR, 3, 8, 1, 2, 1'b0));
    push_word(make_word(OP_ADD, 3, 9, 1, 2, 1'b0));
    push_word(make_word(OP_MUL, 3, 9, 1, 1, 1'b0));
    push_word(make_word(OP_MOVE, 2, 10, 9, 0, 1'b0));
    push_word(make_word(OP_NEG, 2, 11, 1, 0, 1'b0));
    push_word(make_word(OP_ADD, 2, 12, 1, 2, 1'b0));
    push_word(make_word(OP_LDC, 2, 32'(NumRegs), 5, 0, 1'b0));
    push_word(make_word(OP_MOVE, 2, 13, 32'(NumRegs), 0, 1'b0));
    push_word(make_word(5'd23, 3, 1, 2, 3, 1'b0));
    push_word(make_word(5'd31, 1, 32'hffff_ffff, 2, 3, 1'b0));
    push_word(make_word(OP_MOVE, 2, 14, 1, 0, 1'b0));
    push_word(make_word(OP_LDC, 0, 2, 7, 7, 1'b0));
    push_word(make_word(OP_LDC, 1, 32'h7fff_ffff, 7, 7, 1'b0));
    push_word(make_word(OP_LNOT, 2, 15, 3, 0, 1'b1));

    for (int i = 0; i < 1200; i++) begin
      logic [4:0] op;
      logic [1:0] cnt;
      if (i == 600) begin
        while (pending_words.size() != 0 || folded_words.size() != 0) @(posedge clk);
      end
      if ($urandom_range(0, 3) == 0) begin
        push_word(make_word(OP_LDC, 2, pick_reg(),
                            $urandom_range(0, 5) == 0 ? extremes[$urandom_range(0, 3)]
                                                      : pick_value(), $urandom, 1'b0));
        continue;
      end
      op = $urandom_range(0, 9) == 0 ? 5'($urandom_range(23, 31)) : 5'($urandom_range(0, 22));
      cnt = $urandom_range(0, 7) == 0 ? 2'($urandom_range(0, 3))
          : (is_binop(op) ? 2'd3 : is_unop(op) ? 2'd2 : 2'($urandom_range(0, 3)));
      push_word(make_word(op, cnt, pick_reg(), pick_reg(),
                          (op == OP_SHL || op == OP_SHR) && $urandom_range(0, 1) ?
                            32'($urandom_range(0, 40)) : pick_reg(),
                          $urandom_range(0, 60) == 0));
    end
    while (pending_words.size() != 0) @(posedge clk);
    stimulus_done = 1'b1;
  end

  always @(posedge clk) begin
    in_taken <= in_valid && in_ready;
    if (in_valid && in_ready) folded_words = {folded_words, fold_word(in_data)};
    if (out_valid && out_ready) begin
      if (folded_words.size() == 0) begin
        errors++;
        $display("%0t: unexpected result %h", $time, out_data);
      end else begin
        out_word_t e;
        e = folded_words.pop_front();
        if (e !== out_data) begin
          errors++;
          $display("%0t: mismatch expected %h actual %h", $time, e, out_data);
        end
      end
    end
  end

  always @(negedge clk) begin
    if (!rst) begin
      calm <= (cycles > 3000 && cycles < 5000);
      if (!in_valid || in_taken) begin
        if (in_taken) void'(pending_words.pop_front());
        if (pending_words.size() != 0 && (calm || $urandom_range(0, 99) >= 11)) begin
          in_valid <= 1'b1;
          in_data <= pending_words[0];
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(negedge clk) begin
    if (!rst) begin
      if (cycles == 1500) hold_cycles <= 200;
      else if (hold_cycles > 0) hold_cycles <= hold_cycles - 1;
      out_ready <= (hold_cycles == 0 && cycles != 1500) &&
                   (calm || $urandom_range(0, 99) >= 11);
    end
  end

  initial begin
    while (!(stimulus_done && folded_words.size() == 0) && cycles < MaxCycles) @(posedge clk);
    if (cycles >= MaxCycles) begin
      $display("tb: failure");
    end else begin
      repeat (60) @(posedge clk);
      if (errors == 0) $display("tb: success");
      else $display("tb: failure");
    end
    $finish;
  end

  always @(posedge clk) cycles <= cycles + 1;

endmodule
